// ----- hdl/ctp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types, codes and rate table for the caption triplet pacer.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int TripW       = 24;
  localparam int ByteW       = 8;
  localparam int TagPortW    = 32;
  localparam int CountW      = 32;
  localparam int LevelW      = 7;
  localparam int RateW       = 16;
  localparam int BudgetW     = 5;
  localparam int CfgIdxW     = 1;
  localparam int RateEntries = 8;
  localparam int RateIdxW    = 3;
  localparam int CmdDepth    = 2;

  localparam logic [RateW-1:0] RateNumReset = 16'd25;
  localparam logic [RateW-1:0] RateDenReset = 16'd1;

  // input item kinds
  localparam logic KIND_TRIPLET   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RATE_NUM = 1'b0,
    REG_RATE_DEN = 1'b1
  } cfg_reg_e;

  // command codes passed from front to back
  typedef enum logic [2:0] {
    OP_PASS_TRIP = 3'd0,
    OP_PASS_END  = 3'd1,
    OP_QUEUE     = 3'd2,
    OP_SUPPRESS  = 3'd3,
    OP_DRAIN     = 3'd4
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [TripW-1:0]     trip;
    logic [BudgetW-1:0]   budget;
  } cmd_t;

  // standard frame rates, numerator
  function automatic logic [RateW-1:0] rate_num(input logic [RateIdxW-1:0] idx);
    logic [RateW-1:0] v;
    case (idx)
      3'd0:    v = 16'd24000;
      3'd1:    v = 16'd24;
      3'd2:    v = 16'd25;
      3'd3:    v = 16'd30000;
      3'd4:    v = 16'd30;
      3'd5:    v = 16'd50;
      3'd6:    v = 16'd60000;
      3'd7:    v = 16'd60;
      default: v = '0;
    endcase
    return v;
  endfunction

  // standard frame rates, denominator
  function automatic logic [RateW-1:0] rate_den(input logic [RateIdxW-1:0] idx);
    logic [RateW-1:0] v;
    case (idx)
      3'd0, 3'd3, 3'd6: v = 16'd1001;
      default:          v = 16'd1;
    endcase
    return v;
  endfunction

  // triplets per frame for each standard rate
  function automatic logic [BudgetW-1:0] std_budget(input logic [RateIdxW-1:0] idx);
    logic [BudgetW-1:0] v;
    case (idx)
      3'd0, 3'd1: v = 5'd25;
      3'd2:       v = 5'd24;
      3'd3, 3'd4: v = 5'd20;
      3'd5:       v = 5'd12;
      3'd6, 3'd7: v = 5'd10;
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ctp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ctp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ctp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_front
// Holds the rate registers, scans the rate table for the budget and
// classifies each input request into a command for the back end.
// ----------------------------------------------------------------------------
module ctp_front #(
  parameter int TAG_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ctp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctp_pkg::RateW-1:0]     cfg_data_i,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [ctp_pkg::TagPortW-1:0]  frame_tag_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_a_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_b_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_c_i,
  // commands
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output ctp_pkg::cmd_t                 cmd_o
);
  import ctp_pkg::*;

  localparam int TagBits = (TAG_WIDTH < TagPortW) ? TAG_WIDTH : TagPortW;

  logic [RateW-1:0]    num_q, num_d;
  logic [RateW-1:0]    den_q, den_d;
  logic                scan_busy_q, scan_busy_d;
  logic [RateIdxW-1:0] scan_idx_q, scan_idx_d;
  logic [BudgetW-1:0]  budget_q, budget_d;
  logic [TagBits-1:0]  prev_tag_q, prev_tag_d;
  logic                prev_valid_q, prev_valid_d;
  logic [2*RateW-1:0]  lhs, rhs;
  logic                rate_match;
  logic                accept;
  logic [TagBits-1:0]  tag;
  logic                repeated;

  assign cfg_ready_o = 1'b1;

  // cross-multiplied compare against the current table entry
  assign lhs        = rate_num(scan_idx_q) * den_q;
  assign rhs        = rate_den(scan_idx_q) * num_q;
  assign rate_match = (num_q != '0) && (den_q != '0) && (lhs == rhs);

  // input handshake
  assign in_stall_o  = scan_busy_q || cfg_valid_i || !cmd_ready_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = accept;

  assign tag      = frame_tag_i[TagBits-1:0];
  assign repeated = prev_valid_q && (tag == prev_tag_q);

  // classify the request
  always_comb begin
    cmd_o.trip   = {cc_byte_a_i, cc_byte_b_i, cc_byte_c_i};
    cmd_o.budget = budget_q;
    if (budget_q == '0) begin
      cmd_o.op = (kind_i == KIND_FRAME_END) ? OP_PASS_END : OP_PASS_TRIP;
    end else if (kind_i == KIND_FRAME_END) begin
      cmd_o.op = OP_DRAIN;
    end else if (repeated) begin
      cmd_o.op = OP_SUPPRESS;
    end else begin
      cmd_o.op = OP_QUEUE;
    end
  end

  // rate registers and budget scan
  always_comb begin
    num_d        = num_q;
    den_d        = den_q;
    scan_busy_d  = scan_busy_q;
    scan_idx_d   = scan_idx_q;
    budget_d     = budget_q;
    prev_tag_d   = prev_tag_q;
    prev_valid_d = prev_valid_q;

    if (scan_busy_q) begin
      if (rate_match && (budget_q == '0)) begin
        budget_d = std_budget(scan_idx_q);
      end
      if (scan_idx_q == RateIdxW'(RateEntries - 1)) begin
        scan_busy_d = 1'b0;
      end
      scan_idx_d = scan_idx_q + 1'b1;
    end

    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RATE_NUM: num_d = cfg_data_i;
        REG_RATE_DEN: den_d = cfg_data_i;
        default:      num_d = num_q;
      endcase
      scan_busy_d = 1'b1;
      scan_idx_d  = '0;
      budget_d    = '0;
    end

    // paced end of frame records the picture tag
    if (accept && (cmd_o.op == OP_DRAIN)) begin
      prev_tag_d   = tag;
      prev_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q        <= RateNumReset;
      den_q        <= RateDenReset;
      scan_busy_q  <= 1'b1;
      scan_idx_q   <= '0;
      budget_q     <= '0;
      prev_tag_q   <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      num_q        <= num_d;
      den_q        <= den_d;
      scan_busy_q  <= scan_busy_d;
      scan_idx_q   <= scan_idx_d;
      budget_q     <= budget_d;
      prev_tag_q   <= prev_tag_d;
      prev_valid_q <= prev_valid_d;
    end
  end

endmodule

// ----- hdl/ctp_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ctp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ctp_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ctp_pkg::cmd_t pop_data_o
);
  import ctp_pkg::*;

  localparam int PtrW = $clog2(CmdDepth);
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            slot_q [CmdDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(CmdDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ctp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_back
// Carries out commands: keeps the triplet queue and the counters, drains
// the queue at end of frame and holds results in an output register.
// ----------------------------------------------------------------------------
module ctp_back #(
  parameter int MAX_BACKLOG = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // commands
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  ctp_pkg::cmd_t                 cmd_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_data_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_a_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_b_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_c_o,
  output logic                          frame_end_o,
  output logic [ctp_pkg::CountW-1:0]    total_in_o,
  output logic [ctp_pkg::CountW-1:0]    total_out_o,
  output logic [ctp_pkg::CountW-1:0]    total_dropped_o,
  output logic [ctp_pkg::CountW-1:0]    total_suppressed_o,
  output logic [ctp_pkg::LevelW-1:0]    queue_level_o
);
  import ctp_pkg::*;

  localparam int PtrW = $clog2(MAX_BACKLOG);
  localparam int CntW = $clog2(MAX_BACKLOG + 1);
  localparam logic [PtrW-1:0] MaxIdx = PtrW'(MAX_BACKLOG - 1);
  localparam logic [CntW-1:0] Full   = CntW'(MAX_BACKLOG);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == MaxIdx) ? '0 : p + 1'b1;
  endfunction

  state_e              state_q, state_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [BudgetW-1:0]  remain_q, remain_d;
  logic [CountW-1:0]   arrived_q, arrived_d;
  logic [CountW-1:0]   emitted_q, emitted_d;
  logic [CountW-1:0]   dropped_q, dropped_d;
  logic [CountW-1:0]   suppressed_q, suppressed_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                load;
  logic                ld_has, ld_fend;
  logic [TripW-1:0]    ld_trip;
  logic                ram_we, ram_re;
  logic [PtrW-1:0]     ram_raddr;
  logic [TripW-1:0]    ram_rdata;
  logic [BudgetW-1:0]  take;

  // triplet store
  ctp_ram #(
    .WIDTH(TripW),
    .DEPTH(MAX_BACKLOG)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (cmd_i.trip),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (CntW'(cmd_i.budget) < count_q) ? cmd_i.budget : BudgetW'(count_q);

  // command execution
  always_comb begin
    state_d      = state_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    count_d      = count_q;
    remain_d     = remain_q;
    arrived_d    = arrived_q;
    emitted_d    = emitted_q;
    dropped_d    = dropped_q;
    suppressed_d = suppressed_q;
    cmd_ready_o  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rd_ptr_q;
    load         = 1'b0;
    ld_has       = 1'b0;
    ld_trip      = '0;
    ld_fend      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_QUEUE: begin
              cmd_ready_o = 1'b1;
              arrived_d   = arrived_q + 1'b1;
              ram_we      = 1'b1;
              wr_ptr_d    = ptr_next(wr_ptr_q);
              if (count_q == Full) begin
                // overwrite the oldest entry
                rd_ptr_d  = ptr_next(rd_ptr_q);
                dropped_d = dropped_q + 1'b1;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            OP_SUPPRESS: begin
              cmd_ready_o  = 1'b1;
              arrived_d    = arrived_q + 1'b1;
              suppressed_d = suppressed_q + 1'b1;
            end
            OP_PASS_TRIP: begin
              if (out_free) begin
                cmd_ready_o = 1'b1;
                load        = 1'b1;
                ld_has      = 1'b1;
                ld_trip     = cmd_i.trip;
              end
            end
            OP_PASS_END: begin
              if (out_free) begin
                cmd_ready_o = 1'b1;
                load        = 1'b1;
                ld_fend     = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (take == '0) begin
                if (out_free) begin
                  cmd_ready_o = 1'b1;
                  load        = 1'b1;
                  ld_fend     = 1'b1;
                end
              end else begin
                cmd_ready_o = 1'b1;
                ram_re      = 1'b1;
                remain_d    = take;
                state_d     = ST_DRAIN;
              end
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // one queued triplet per cycle while the output is free
        if (out_free) begin
          load      = 1'b1;
          ld_has    = 1'b1;
          ld_trip   = ram_rdata;
          ld_fend   = (remain_q == BudgetW'(1));
          emitted_d = emitted_q + 1'b1;
          count_d   = count_q - 1'b1;
          rd_ptr_d  = ptr_next(rd_ptr_q);
          remain_d  = remain_q - 1'b1;
          if (remain_q == BudgetW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_next(rd_ptr_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      has_data_o         <= ld_has;
      out_byte_a_o       <= ld_trip[TripW-1 -: ByteW];
      out_byte_b_o       <= ld_trip[TripW-ByteW-1 -: ByteW];
      out_byte_c_o       <= ld_trip[ByteW-1:0];
      frame_end_o        <= ld_fend;
      total_in_o         <= arrived_d;
      total_out_o        <= emitted_d;
      total_dropped_o    <= dropped_d;
      total_suppressed_o <= suppressed_d;
      queue_level_o      <= LevelW'(count_d);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      count_q      <= '0;
      remain_q     <= '0;
      arrived_q    <= '0;
      emitted_q    <= '0;
      dropped_q    <= '0;
      suppressed_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      count_q      <= count_d;
      remain_q     <= remain_d;
      arrived_q    <= arrived_d;
      emitted_q    <= emitted_d;
      dropped_q    <= dropped_d;
      suppressed_q <= suppressed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/caption_triplet_pacer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caption_triplet_pacer
// Paces caption triplets to a per-frame budget taken from the frame rate.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o | kind, frame_tag, cc_byte_a/b/c
//   result   | out_valid_o / out_stall_i | has_data, bytes, frame_end, totals
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// In idle the back end accepts a queued or suppressed request whenever it is
// offered, and a pass-through request when the output register is free. End
// of frame starts a read of the triplet store, then emits one queued triplet
// per cycle while the output is free, set by the single read port of the
// triplet store. After reset and after each config write the front scans the
// rate table, and input requests stall until the scan ends. A stalled result
// holds in the output register; the front accepts until the command FIFO fills.
// ----------------------------------------------------------------------------
module caption_triplet_pacer #(
  parameter int MAX_BACKLOG = 64,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ctp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctp_pkg::RateW-1:0]     cfg_data_i,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [ctp_pkg::TagPortW-1:0]  frame_tag_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_a_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_b_i,
  input  logic [ctp_pkg::ByteW-1:0]     cc_byte_c_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_data_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_a_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_b_o,
  output logic [ctp_pkg::ByteW-1:0]     out_byte_c_o,
  output logic                          frame_end_o,
  output logic [ctp_pkg::CountW-1:0]    total_in_o,
  output logic [ctp_pkg::CountW-1:0]    total_out_o,
  output logic [ctp_pkg::CountW-1:0]    total_dropped_o,
  output logic [ctp_pkg::CountW-1:0]    total_suppressed_o,
  output logic [ctp_pkg::LevelW-1:0]    queue_level_o
);
  import ctp_pkg::*;

  logic cf_push_valid, cf_push_ready;
  logic cf_pop_valid, cf_pop_ready;
  cmd_t cf_push_data, cf_pop_data;

  // front end: rate lookup and classification
  ctp_front #(
    .TAG_WIDTH(TAG_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .frame_tag_i (frame_tag_i),
    .cc_byte_a_i (cc_byte_a_i),
    .cc_byte_b_i (cc_byte_b_i),
    .cc_byte_c_i (cc_byte_c_i),
    .cmd_valid_o (cf_push_valid),
    .cmd_ready_i (cf_push_ready),
    .cmd_o       (cf_push_data)
  );

  // command queue
  ctp_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cf_push_valid),
    .push_ready_o (cf_push_ready),
    .push_data_i  (cf_push_data),
    .pop_valid_o  (cf_pop_valid),
    .pop_ready_i  (cf_pop_ready),
    .pop_data_o   (cf_pop_data)
  );

  // back end: triplet queue, counters and results
  ctp_back #(
    .MAX_BACKLOG(MAX_BACKLOG)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (cf_pop_valid),
    .cmd_ready_o        (cf_pop_ready),
    .cmd_i              (cf_pop_data),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .has_data_o         (has_data_o),
    .out_byte_a_o       (out_byte_a_o),
    .out_byte_b_o       (out_byte_b_o),
    .out_byte_c_o       (out_byte_c_o),
    .frame_end_o        (frame_end_o),
    .total_in_o         (total_in_o),
    .total_out_o        (total_out_o),
    .total_dropped_o    (total_dropped_o),
    .total_suppressed_o (total_suppressed_o),
    .queue_level_o      (queue_level_o)
  );

endmodule

// ----- hdl/ctp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks for the caption triplet pacer, bound to the top level.
// ----------------------------------------------------------------------------
module ctp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          has_data_o,
  input  logic [ctp_pkg::ByteW-1:0]     out_byte_a_o,
  input  logic [ctp_pkg::ByteW-1:0]     out_byte_b_o,
  input  logic [ctp_pkg::ByteW-1:0]     out_byte_c_o,
  input  logic                          frame_end_o,
  input  logic [ctp_pkg::CountW-1:0]    total_out_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps byte a, its frame end flag and its output total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_a_o) && $stable(frame_end_o)
      && $stable(total_out_o))
    else $error("stalled result changed");

  // an empty marker always closes a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> frame_end_o)
    else $error("empty marker without frame end");

  // an empty marker carries zero bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |->
      (out_byte_a_o == '0) && (out_byte_b_o == '0) && (out_byte_c_o == '0))
    else $error("empty marker with data bytes");

  // no request is taken while a rate register is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> in_stall_o)
    else $error("request taken during config write");

endmodule

bind caption_triplet_pacer ctp_checker u_ctp_checker (.*);
